@@ sv/dtp_pkg.sv @@
// Shared types and constants for the dominated task pruner.
package dtp_pkg;

  localparam int COST_W       = 16;
  localparam int MASK_W       = 64;
  localparam int INDEX_W      = 6;
  localparam int RESULT_LIMIT = 64;

  typedef struct packed {
    logic signed [COST_W-1:0] task_cost;
    logic [MASK_W-1:0]        worker_mask;
    logic                     last_task;
  } in_t;

  typedef struct packed {
    logic [INDEX_W-1:0]       original_index;
    logic signed [COST_W-1:0] kept_cost;
    logic [MASK_W-1:0]        kept_mask;
    logic                     overflowed;
    logic                     last_kept;
  } out_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PRUNE = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

endpackage

@@ sv/dtp_cell.sv @@
// One storage cell of the task ring: holds a task and passes it on when shifted.
module dtp_cell #(
  parameter int WORKER_BITS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dtp_pkg::cell_ctl_t                ctl,
  input  logic                              vld_i,
  input  logic                              keep_i,
  input  logic signed [dtp_pkg::COST_W-1:0] cost_i,
  input  logic [WORKER_BITS-1:0]            mask_i,
  output logic                              vld_o,
  output logic                              keep_o,
  output logic signed [dtp_pkg::COST_W-1:0] cost_o,
  output logic [WORKER_BITS-1:0]            mask_o
);
  import dtp_pkg::*;

  logic                     vld_r;
  logic                     keep_r;
  logic signed [COST_W-1:0] cost_r;
  logic [WORKER_BITS-1:0]   mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.clear) begin
      vld_r <= 1'b0;
    end else if (ctl.shift) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      keep_r <= keep_i;
      cost_r <= cost_i;
      mask_r <= mask_i;
    end
  end

  assign vld_o  = vld_r;
  assign keep_o = keep_r;
  assign cost_o = cost_r;
  assign mask_o = mask_r;

endmodule

@@ sv/dtp_ctrl.sv @@
// Sequencer: loads tasks into the ring, runs the dominance passes and emits kept tasks.
module dtp_ctrl #(
  parameter int MAX_TASKS   = 64,
  parameter int WORKER_BITS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  dtp_pkg::in_t                      in_item,
  output logic                              out_valid,
  output dtp_pkg::out_t                     out_item,
  output dtp_pkg::cell_ctl_t                ctl,
  input  logic                              head_vld,
  input  logic                              head_keep,
  input  logic signed [dtp_pkg::COST_W-1:0] head_cost,
  input  logic [WORKER_BITS-1:0]            head_mask,
  output logic                              tail_vld,
  output logic                              tail_keep,
  output logic signed [dtp_pkg::COST_W-1:0] tail_cost,
  output logic [WORKER_BITS-1:0]            tail_mask
);
  import dtp_pkg::*;

  localparam int KW = $clog2(MAX_TASKS + 1);
  localparam int PW = $clog2(MAX_TASKS);
  localparam int EW = $clog2(RESULT_LIMIT + 1);
  localparam int CW = (KW > EW) ? KW : EW;

  state_t                   state_r, state_nxt;
  logic [KW-1:0]            cnt_r, cnt_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [PW-1:0]            pos_r, pos_nxt;
  logic [KW-1:0]            step_r, step_nxt;
  logic                     dom_r, dom_nxt;
  logic signed [COST_W-1:0] pcost_r, pcost_nxt;
  logic [WORKER_BITS-1:0]   pmask_r, pmask_nxt;
  logic [KW-1:0]            kept_r, kept_nxt;
  logic [KW-1:0]            idx_r, idx_nxt;
  logic [EW-1:0]            emit_n_r, emit_n_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_t                     out_item_r, out_item_nxt;

  logic                     full;
  logic                     hit;
  logic                     advance;
  logic [CW-1:0]            lim;

  assign full = (cnt_r == KW'(MAX_TASKS));
  assign hit  = head_vld && head_keep && ((head_mask & ~pmask_r) == '0) &&
                (head_cost <= pcost_r);
  assign lim  = (CW'(kept_r) < CW'(RESULT_LIMIT)) ? CW'(kept_r) : CW'(RESULT_LIMIT);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    pos_nxt       = pos_r;
    step_nxt      = step_r;
    dom_nxt       = dom_r;
    pcost_nxt     = pcost_r;
    pmask_nxt     = pmask_r;
    kept_nxt      = kept_r;
    idx_nxt       = idx_r;
    emit_n_nxt    = emit_n_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    ctl           = '0;
    advance       = 1'b0;
    tail_vld      = head_vld;
    tail_keep     = head_keep;
    tail_cost     = head_cost;
    tail_mask     = head_mask;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (!full) begin
            ctl.shift = 1'b1;
            tail_vld  = 1'b1;
            tail_keep = 1'b1;
            tail_cost = in_item.task_cost;
            tail_mask = in_item.worker_mask[WORKER_BITS-1:0];
            cnt_nxt   = cnt_r + KW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_item.last_task) begin
            state_nxt = ST_PRUNE;
            pos_nxt   = '0;
            step_nxt  = '0;
            kept_nxt  = full ? cnt_r : cnt_r + KW'(1);
          end
        end
      end
      ST_PRUNE: begin
        ctl.shift = 1'b1;
        if (step_r == '0) begin
          if (head_vld) begin
            pcost_nxt = head_cost;
            pmask_nxt = head_mask;
            dom_nxt   = 1'b0;
            step_nxt  = KW'(1);
          end else begin
            advance = 1'b1;
          end
        end else if (step_r == KW'(MAX_TASKS)) begin
          // candidate is back at the head: write its verdict on the way round
          tail_keep = head_keep & ~dom_r;
          if (dom_r) begin
            kept_nxt = kept_r - KW'(1);
          end
          step_nxt = '0;
          advance  = 1'b1;
        end else begin
          dom_nxt  = dom_r | hit;
          step_nxt = step_r + KW'(1);
        end
        if (advance) begin
          if (pos_r == PW'(MAX_TASKS - 1)) begin
            state_nxt  = ST_EMIT;
            pos_nxt    = '0;
            idx_nxt    = '0;
            emit_n_nxt = '0;
          end else begin
            pos_nxt = pos_r + PW'(1);
          end
        end
      end
      ST_EMIT: begin
        ctl.shift = 1'b1;
        if (head_vld) begin
          idx_nxt = idx_r + KW'(1);
        end
        if (head_vld && head_keep && (emit_n_r < EW'(RESULT_LIMIT))) begin
          out_valid_nxt               = 1'b1;
          out_item_nxt.original_index = INDEX_W'(idx_r);
          out_item_nxt.kept_cost      = head_cost;
          out_item_nxt.kept_mask      = MASK_W'(head_mask);
          out_item_nxt.overflowed     = ovf_r;
          out_item_nxt.last_kept      = (CW'(emit_n_r) == lim - CW'(1));
          emit_n_nxt                  = emit_n_r + EW'(1);
        end
        if (pos_r == PW'(MAX_TASKS - 1)) begin
          ctl.clear = 1'b1;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          pos_nxt = pos_r + PW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      pos_r       <= '0;
      step_r      <= '0;
      dom_r       <= 1'b0;
      kept_r      <= '0;
      idx_r       <= '0;
      emit_n_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      pos_r       <= pos_nxt;
      step_r      <= step_nxt;
      dom_r       <= dom_nxt;
      kept_r      <= kept_nxt;
      idx_r       <= idx_nxt;
      emit_n_r    <= emit_n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pcost_r    <= pcost_nxt;
    pmask_r    <= pmask_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_EMIT))
    else $error("result strobe outside emit pass");

  a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.last_kept) |=> !out_valid_r)
    else $error("result after final kept task");

  a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (kept_r <= cnt_r))
    else $error("kept count exceeds stored tasks");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= KW'(MAX_TASKS))
    else $error("task count beyond capacity");

endmodule

@@ sv/dominated_task_pruner.sv @@
// Dominated task pruner: ring of task cells plus sequencer.
// A task that is not last is taken while busy stays low.
// On the last task, each stored task gets a dominance pass round the ring and each empty
// slot is skipped, with one dominance check per cycle at the ring head; then an emit pass.
// Results follow in the cycle after their task reaches the head; the receiver cannot stall.
// Reset (synchronous, rst_n low) empties the ring and clears count and overflow.
module dominated_task_pruner #(
  parameter int MAX_TASKS   = 64,
  parameter int WORKER_BITS = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  dtp_pkg::in_t   in_item,
  output logic           out_valid,
  output dtp_pkg::out_t  out_item
);
  import dtp_pkg::*;

  cell_ctl_t                ctl;
  logic                     vld_w  [MAX_TASKS];
  logic                     keep_w [MAX_TASKS];
  logic signed [COST_W-1:0] cost_w [MAX_TASKS];
  logic [WORKER_BITS-1:0]   mask_w [MAX_TASKS];
  logic                     tail_vld;
  logic                     tail_keep;
  logic signed [COST_W-1:0] tail_cost;
  logic [WORKER_BITS-1:0]   tail_mask;

  for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
    if (k == MAX_TASKS - 1) begin : g_tail
      dtp_cell #(.WORKER_BITS(WORKER_BITS)) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .vld_i  (tail_vld),
        .keep_i (tail_keep),
        .cost_i (tail_cost),
        .mask_i (tail_mask),
        .vld_o  (vld_w[k]),
        .keep_o (keep_w[k]),
        .cost_o (cost_w[k]),
        .mask_o (mask_w[k])
      );
    end else begin : g_mid
      dtp_cell #(.WORKER_BITS(WORKER_BITS)) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .vld_i  (vld_w[k+1]),
        .keep_i (keep_w[k+1]),
        .cost_i (cost_w[k+1]),
        .mask_i (mask_w[k+1]),
        .vld_o  (vld_w[k]),
        .keep_o (keep_w[k]),
        .cost_o (cost_w[k]),
        .mask_o (mask_w[k])
      );
    end
  end

  dtp_ctrl #(
    .MAX_TASKS   (MAX_TASKS),
    .WORKER_BITS (WORKER_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .ctl       (ctl),
    .head_vld  (vld_w[0]),
    .head_keep (keep_w[0]),
    .head_cost (cost_w[0]),
    .head_mask (mask_w[0]),
    .tail_vld  (tail_vld),
    .tail_keep (tail_keep),
    .tail_cost (tail_cost),
    .tail_mask (tail_mask)
  );

endmodule

@@ dv/dtp_checker.sv @@
// Checker for the dominated task pruner: watches both channels, predicts kept tasks, compares.
`timescale 1ns / 1ps

module dtp_checker #(
  parameter int MAX_TASKS   = 64,
  parameter int WORKER_BITS = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  dtp_pkg::in_t   in_item,
  input  logic           out_valid,
  input  dtp_pkg::out_t  out_item,
  output int             fail_count,
  output int             pending_count
);
  import dtp_pkg::*;

  localparam logic [MASK_W-1:0] WORKER_KEEP = {MASK_W{1'b1}} >> (MASK_W - WORKER_BITS);

  logic signed [COST_W-1:0] cost_mem [MAX_TASKS];
  logic [MASK_W-1:0]        mask_mem [MAX_TASKS];
  bit                       kept     [MAX_TASKS];
  int                       n_loaded;
  bit                       spilled;
  out_t                     kept_expect_q [$];

  function automatic void clear_set();
    for (int i = 0; i < MAX_TASKS; i++) kept[i] = 1'b1;
    n_loaded = 0;
    spilled  = 1'b0;
  endfunction

  // walk in load order; later tasks still count as kept until their own turn
  function automatic void prune_dominated();
    int   last_i;
    int   n_out;
    out_t r;
    last_i = -1;
    n_out  = 0;
    for (int i = 0; i < n_loaded; i++) begin
      if (kept[i]) begin
        for (int j = 0; j < n_loaded; j++) begin
          if (j != i && kept[j] && (mask_mem[j] & ~mask_mem[i]) == '0 &&
              cost_mem[j] <= cost_mem[i]) begin
            kept[i] = 1'b0;
            break;
          end
        end
      end
    end
    for (int i = 0; i < n_loaded; i++) begin
      if (kept[i] && n_out < RESULT_LIMIT) begin
        last_i = i;
        n_out++;
      end
    end
    n_out = 0;
    for (int i = 0; i < n_loaded && n_out < RESULT_LIMIT; i++) begin
      if (kept[i]) begin
        r.original_index = i[INDEX_W-1:0];
        r.kept_cost      = cost_mem[i];
        r.kept_mask      = mask_mem[i];
        r.overflowed     = spilled;
        r.last_kept      = (i == last_i);
        kept_expect_q.insert(kept_expect_q.size(), r);
        n_out++;
      end
    end
    clear_set();
  endfunction

  function automatic void load_task(in_t t);
    if (n_loaded < MAX_TASKS) begin
      cost_mem[n_loaded] = t.task_cost;
      mask_mem[n_loaded] = t.worker_mask & WORKER_KEEP;
      kept[n_loaded]     = 1'b1;
      n_loaded++;
    end else begin
      spilled = 1'b1;
    end
    if (t.last_task) prune_dominated();
  endfunction

  function automatic void flag_field(string field, logic [63:0] want, logic [63:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endfunction

  function automatic void check_result(out_t got);
    out_t want;
    if (kept_expect_q.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      return;
    end
    want = kept_expect_q.pop_front();
    if (got.original_index !== want.original_index)
      flag_field("original_index", 64'(want.original_index), 64'(got.original_index));
    if (got.kept_cost !== want.kept_cost)
      flag_field("kept_cost", 64'(unsigned'(want.kept_cost)), 64'(unsigned'(got.kept_cost)));
    if (got.kept_mask !== want.kept_mask)
      flag_field("kept_mask", want.kept_mask, got.kept_mask);
    if (got.overflowed !== want.overflowed)
      flag_field("overflowed", 64'(want.overflowed), 64'(got.overflowed));
    if (got.last_kept !== want.last_kept)
      flag_field("last_kept", 64'(want.last_kept), 64'(got.last_kept));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_set();
      kept_expect_q.delete();
    end else begin
      if (out_valid === 1'b1) check_result(out_item);
      else if (out_valid !== 1'b0) flag_field("out_valid", 64'd0, 64'(out_valid));
      if (start && busy === 1'b0) load_task(in_item);
    end
    pending_count = kept_expect_q.size();
  end

endmodule

@@ dv/tb_dominated_task_pruner.sv @@
// Testbench top for the dominated task pruner: reset, task stimulus and verdict.
`timescale 1ns / 1ps

module tb_dominated_task_pruner;
  import dtp_pkg::*;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_item;
  logic out_valid;
  out_t out_item;
  int   fail_count;
  int   pending_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  dominated_task_pruner #(
    .MAX_TASKS   (64),
    .WORKER_BITS (64)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  dtp_checker #(
    .MAX_TASKS   (64),
    .WORKER_BITS (64)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_item      (out_item),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic send_task(input logic signed [COST_W-1:0] cost, input logic [MASK_W-1:0] mask,
                           input logic last, input int gap);
    in_t t;
    t.task_cost   = cost;
    t.worker_mask = mask;
    t.last_task   = last;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= t;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    wait (pending_count == 0);
  endtask

  function automatic logic [MASK_W-1:0] pick_mask(bit narrow, int base);
    logic [MASK_W-1:0] raw;
    int unsigned       pick;
    raw  = {$urandom, $urandom};
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return narrow ? raw & (64'h3F << base) : raw;
  endfunction

  initial begin
    int                       sent;
    int                       set_no;
    int                       set_len;
    int                       base;
    int                       sel;
    bit                       narrow;
    bit                       no_gaps;
    logic signed [COST_W-1:0] cost;

    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single task, extreme cost and full mask
    send_task(16'sh8000, '1, 1'b1, $urandom_range(0, 8));
    // identical tasks: only the last loaded survives
    send_task(16'sd5, 64'hF0, 1'b0, $urandom_range(0, 8));
    send_task(16'sd5, 64'hF0, 1'b0, $urandom_range(0, 8));
    send_task(16'sd5, 64'hF0, 1'b1, $urandom_range(0, 8));
    drain_results();
    // empty mask, max and min cost, top and bottom workers
    send_task(16'sh7FFF, '0, 1'b0, $urandom_range(0, 8));
    send_task(16'sh8000, '1, 1'b0, $urandom_range(0, 8));
    send_task(16'sd0, 64'h8000_0000_0000_0001, 1'b0, $urandom_range(0, 8));
    send_task(-16'sd1, 64'h1, 1'b1, $urandom_range(0, 8));
    // dominance by tasks loaded later
    send_task(16'sd10, 64'h6, 1'b0, $urandom_range(0, 8));
    send_task(16'sd10, 64'h2, 1'b0, $urandom_range(0, 8));
    send_task(16'sd9, 64'h6, 1'b0, $urandom_range(0, 8));
    send_task(16'sd11, 64'h2, 1'b1, $urandom_range(0, 8));
    // alternating bit patterns
    send_task(16'sh5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, $urandom_range(0, 8));
    send_task(16'shAAAA, 64'h5555_5555_5555_5555, 1'b1, $urandom_range(0, 8));
    // empty masks with ties
    send_task(16'sd0, '0, 1'b0, 0);
    send_task(16'sd0, '0, 1'b0, 0);
    send_task(-16'sd1, '0, 1'b1, 0);
    drain_results();

    sent   = 0;
    set_no = 0;
    while (sent < 380) begin
      sel = $urandom_range(0, 19);
      if (set_no == 0) set_len = 66;
      else if (set_no == 1) set_len = 64;
      else if (sel == 0) set_len = $urandom_range(63, 70);
      else if (sel < 3) set_len = $urandom_range(20, 40);
      else set_len = $urandom_range(1, 8);
      narrow  = ($urandom_range(0, 3) != 0);
      no_gaps = ($urandom_range(0, 3) == 0);
      base    = $urandom_range(0, 58);
      for (int k = 0; k < set_len; k++) begin
        if (narrow) cost = COST_W'(int'($urandom_range(0, 6)) - 3);
        else cost = COST_W'($urandom);
        send_task(cost, pick_mask(narrow, base), k == set_len - 1,
                  no_gaps ? 0 : $urandom_range(0, 8));
        sent++;
      end
      if (set_no == 0 || $urandom_range(0, 2) == 0) drain_results();
      set_no++;
    end

    drain_results();
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/dtp_pkg.sv
sv/dtp_cell.sv
sv/dtp_ctrl.sv
sv/dominated_task_pruner.sv
dv/dtp_checker.sv
dv/tb_dominated_task_pruner.sv
